// File: hdl/nearest_centroid_of_buffer_macros.svh
`ifndef NEAREST_CENTROID_OF_BUFFER_MACROS_SVH
`define NEAREST_CENTROID_OF_BUFFER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define NCB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define NCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ncb_pkg.sv
package ncb_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int DIMENSIONS  = 4;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 4;
  localparam int ENTRY_W = 3;
  localparam int DIM_W   = 2;
  localparam int ACC_W   = 64;

  localparam int DEPTH      = MAX_ENTRIES * DIMENSIONS;
  localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NUM_W      = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIV_STEP_W = $clog2(VALUE_W);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_MUL,
    S_ACC,
    S_FINIT,
    S_FIND
  } state_t;

  typedef struct packed {
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic              div_start;
    logic              mul_en;
    logic              acc_en;
    logic              acc_clear;
    logic              find_init;
    logic              find_step;
    logic [IDX_W-1:0]  idx;
  } ctrl_t;

endpackage

// File: hdl/ncb_divider.sv
module ncb_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [ncb_pkg::VALUE_W-1:0]  dividend,
  input  logic        [ncb_pkg::COUNT_W-1:0]  divisor,
  output logic                                done,
  output logic signed [ncb_pkg::VALUE_W-1:0]  quotient
);
  import ncb_pkg::*;

  logic                  busy;
  logic [DIV_STEP_W-1:0] step;
  logic                  neg;
  logic [VALUE_W-1:0]    dq;
  logic [COUNT_W-1:0]    rem;
  logic [COUNT_W-1:0]    dvs;

  logic [VALUE_W-1:0]    mag;
  logic [COUNT_W:0]      rem_sh;
  logic [COUNT_W:0]      rem_sub;
  logic                  fits;
  logic [VALUE_W-1:0]    q_next;

  always_comb begin
    mag     = dividend[VALUE_W-1] ? (~dividend + VALUE_W'(1)) : dividend;
    rem_sh  = {rem, dq[VALUE_W-1]};
    fits    = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
    q_next  = {dq[VALUE_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + DIV_STEP_W'(1);
        if (step == DIV_STEP_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= mag;
      rem <= '0;
      neg <= dividend[VALUE_W-1];
      dvs <= (divisor == '0) ? COUNT_W'(1) : divisor;
    end else if (busy) begin
      dq  <= q_next;
      rem <= fits ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      if (step == DIV_STEP_W'(VALUE_W - 1)) begin
        quotient <= $signed(neg ? (~q_next + VALUE_W'(1)) : q_next);
      end
    end
  end

endmodule

// File: hdl/ncb_mean_mem.sv
module ncb_mean_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic                        re,
  input  logic [ncb_pkg::ADDR_W-1:0]  addr,
  input  logic [ncb_pkg::VALUE_W-1:0] wdata,
  output logic [ncb_pkg::VALUE_W-1:0] rdata
);
  import ncb_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hdl/ncb_dist_unit.sv
module ncb_dist_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  ncb_pkg::ctrl_t                     ctrl,
  input  logic signed [ncb_pkg::VALUE_W-1:0] quotient,
  input  logic        [ncb_pkg::VALUE_W-1:0] mean_rd,
  output logic        [ncb_pkg::IDX_W-1:0]   best_idx
);
  import ncb_pkg::*;

  logic [ACC_W-1:0]   acc [MAX_ENTRIES];
  logic [ACC_W-1:0]   prod;
  logic [ACC_W-1:0]   min_val;

  logic [VALUE_W:0]   diff;
  logic [VALUE_W:0]   diff_abs;
  logic [VALUE_W-1:0] mag;
  logic [ACC_W:0]     sum;
  logic [ACC_W-1:0]   sum_sat;

  always_comb begin
    diff     = {quotient[VALUE_W-1], quotient} - {mean_rd[VALUE_W-1], mean_rd};
    diff_abs = diff[VALUE_W] ? (~diff + (VALUE_W+1)'(1)) : diff;
    mag      = diff_abs[VALUE_W-1:0];
    sum      = {1'b0, acc[ctrl.idx]} + {1'b0, prod};
    sum_sat  = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        acc[i] <= '0;
      end
    end else if (ctrl.acc_clear) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        acc[i] <= '0;
      end
    end else if (ctrl.acc_en) begin
      acc[ctrl.idx] <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= ACC_W'(mag) * ACC_W'(mag);
    end
    if (ctrl.find_init) begin
      min_val  <= acc[0];
      best_idx <= '0;
    end else if (ctrl.find_step && (acc[ctrl.idx] < min_val)) begin
      min_val  <= acc[ctrl.idx];
      best_idx <= ctrl.idx;
    end
  end

endmodule

// File: hdl/ncb_seq.sv
`include "nearest_centroid_of_buffer_macros.svh"

module ncb_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ncb_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [ncb_pkg::ENTRY_W-1:0] entry_index,
  input  logic [ncb_pkg::DIM_W-1:0]   dim_index,
  input  logic                        last,
  input  logic                        div_done,
  input  logic [ncb_pkg::IDX_W-1:0]   best_idx,
  output ncb_pkg::ctrl_t              ctrl,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ncb_pkg::ENTRY_W-1:0] best_entry,
  output logic                        found
);
  import ncb_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [CFG_W-1:0]   entries_in_use;
  logic [NUM_W-1:0]   n;
  logic [NUM_W-1:0]   idx;
  logic [DIM_W-1:0]   dim_q;
  logic               last_q;

  logic               accept;
  logic               is_query;
  logic               dim_ok;
  logic               wr_ok;
  logic [NUM_W-1:0]   n_cfg;
  logic               acc_last;
  logic               find_done;
  logic               out_free;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;

  always_comb begin
    accept    = in_valid && in_ready;
    is_query  = req_type == REQ_QUERY;
    dim_ok    = int'(dim_index) < DIMENSIONS;
    wr_ok     = (int'(entry_index) < MAX_ENTRIES) && dim_ok;
    n_cfg     = (int'(entries_in_use) > MAX_ENTRIES) ? NUM_W'(MAX_ENTRIES)
                                                     : NUM_W'(entries_in_use);
    acc_last  = (idx + NUM_W'(1)) == n;
    find_done = idx >= n;
    out_free  = !out_valid || out_ready;
    waddr     = ADDR_W'(int'(entry_index) * DIMENSIONS + int'(dim_index));
    raddr     = ADDR_W'(int'(idx[IDX_W-1:0]) * DIMENSIONS + int'(dim_q));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && is_query) begin
          if (dim_ok) begin
            state_next = S_DIV;
          end else if (last) begin
            state_next = S_FINIT;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (n != '0) begin
            state_next = S_READ;
          end else begin
            state_next = last_q ? S_FINIT : S_IDLE;
          end
        end
      end
      S_READ: state_next = S_MUL;
      S_MUL:  state_next = S_ACC;
      S_ACC: begin
        if (acc_last) begin
          state_next = last_q ? S_FINIT : S_IDLE;
        end else begin
          state_next = S_READ;
        end
      end
      S_FINIT: state_next = S_FIND;
      S_FIND: begin
        if (find_done && out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctrl     = '0;
    ctrl.idx = idx[IDX_W-1:0];
    ctrl.mem_addr = (state == S_IDLE) ? waddr : raddr;
    unique case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        ctrl.mem_we    = accept && !is_query && wr_ok;
        ctrl.div_start = accept && is_query && dim_ok;
      end
      S_READ:  ctrl.mem_re    = 1'b1;
      S_MUL:   ctrl.mul_en    = 1'b1;
      S_ACC:   ctrl.acc_en    = 1'b1;
      S_FINIT: ctrl.find_init = 1'b1;
      S_FIND: begin
        ctrl.find_step = !find_done;
        ctrl.acc_clear = find_done && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entries_in_use <= '0;
      out_valid      <= 1'b0;
      idx            <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        entries_in_use <= cfg_wdata;
      end
      if (ctrl.acc_clear) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_DIV:   idx <= '0;
        S_ACC:   idx <= idx + NUM_W'(1);
        S_FINIT: idx <= NUM_W'(1);
        S_FIND: begin
          if (!find_done) begin
            idx <= idx + NUM_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      n      <= n_cfg;
      dim_q  <= dim_index;
      last_q <= last;
    end
    if (ctrl.acc_clear) begin
      best_entry <= ENTRY_W'(best_idx);
      found      <= n != '0;
    end
  end

  `NCB_ASSERT_NEXT(a_busy_after_start, ctrl.div_start, !in_ready, "accepted request during divide")
  `NCB_ASSERT_IMPLIES(a_no_overwrite, ctrl.acc_clear, !out_valid || out_ready, "result overwritten")
  `NCB_ASSERT_IMPLIES(a_acc_in_range, ctrl.acc_en, idx < n, "accumulate beyond active entries")
  `NCB_ASSERT_NEXT(a_result_posted, ctrl.acc_clear, out_valid && (found == (n != '0)), "bad result")

endmodule

// File: hdl/nearest_centroid_of_buffer.sv
// Mean write: stored in the mean table when accepted, a new request every cycle while no query is in progress.
// Query component: the 32-step serial divider, then the shared multiply-accumulate path
// (read, square, add per entry) over the n active entries.
// Last component adds the minimum search (S_FINIT, then S_FIND over the entries), plus any wait
// for out_ready while the previous result is still held.
// Reset (rst, synchronous): clears control, entries_in_use and accumulators, not the mean table.
module nearest_centroid_of_buffer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic        [ncb_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               req_type,
  input  logic        [ncb_pkg::ENTRY_W-1:0] entry_index,
  input  logic        [ncb_pkg::DIM_W-1:0]   dim_index,
  input  logic signed [ncb_pkg::VALUE_W-1:0] value,
  input  logic        [ncb_pkg::COUNT_W-1:0] point_count,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [ncb_pkg::ENTRY_W-1:0] best_entry,
  output logic                               found
);
  import ncb_pkg::*;

  ctrl_t                      ctrl;
  logic                       div_done;
  logic signed [VALUE_W-1:0]  quotient;
  logic        [VALUE_W-1:0]  mean_rd;
  logic        [IDX_W-1:0]    best_idx;

  ncb_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .entry_index (entry_index),
    .dim_index   (dim_index),
    .last        (last),
    .div_done    (div_done),
    .best_idx    (best_idx),
    .ctrl        (ctrl),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .best_entry  (best_entry),
    .found       (found)
  );

  ncb_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (value),
    .divisor  (point_count),
    .done     (div_done),
    .quotient (quotient)
  );

  ncb_mean_mem u_mem (
    .clk   (clk),
    .we    (ctrl.mem_we),
    .re    (ctrl.mem_re),
    .addr  (ctrl.mem_addr),
    .wdata (value),
    .rdata (mean_rd)
  );

  ncb_dist_unit u_dist (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .quotient (quotient),
    .mean_rd  (mean_rd),
    .best_idx (best_idx)
  );

endmodule
